FILE: rtl/core/keyword_token_lexer_unit_assert.svh
// Assertion macros used by the lexer checker.
`ifndef KEYWORD_TOKEN_LEXER_UNIT_ASSERT_SVH
`define KEYWORD_TOKEN_LEXER_UNIT_ASSERT_SVH

// Checked at every clock edge outside reset.
`define KWTL_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define KWTL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/kwtl_pkg.sv
// Types and constants of the keyword token lexer.
`timescale 1ns / 1ps

package kwtl_pkg;

  typedef enum logic [3:0] {
    TT_FUNC    = 4'd0,
    TT_RETURN  = 4'd1,
    TT_IF      = 4'd2,
    TT_ELSE    = 4'd3,
    TT_PRINT   = 4'd4,
    TT_IDENT   = 4'd5,
    TT_NUMBER  = 4'd6,
    TT_LBRACE  = 4'd7,
    TT_RBRACE  = 4'd8,
    TT_LPAREN  = 4'd9,
    TT_RPAREN  = 4'd10,
    TT_ASSIGN  = 4'd11,
    TT_PLUS    = 4'd12,
    TT_GREATER = 4'd13,
    TT_UNKNOWN = 4'd14,
    TT_END     = 4'd15
  } tok_type_t;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_IDENT  = 3'b010,
    MODE_NUMBER = 3'b100
  } scan_mode_t;

  typedef struct packed {
    tok_type_t   kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [7:0]  code;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } scan_out_t;

  // Keyword text, first character in the lowest byte.
  localparam logic [31:0] KW_FUNC   = 32'h636E_7566;
  localparam logic [47:0] KW_RETURN = 48'h6E72_7574_6572;
  localparam logic [15:0] KW_IF     = 16'h6669;
  localparam logic [31:0] KW_ELSE   = 32'h6573_6C65;
  localparam logic [39:0] KW_PRINT  = 40'h74_6E69_7270;

  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_ASSIGN     = 8'h3D;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_GREATER    = 8'h3E;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_SPACE      = 8'h20;

  localparam int TDATA_BITS = 48;

endpackage

FILE: rtl/core/keyword_token_lexer_unit.sv
// Top level of the keyword token lexer: byte stream in, token stream out.
//
// Input channel s_axis: one source byte per transfer in tdata; a transfer with
// tlast set marks end of text (its tdata is ignored), flushes any pending token,
// gives an end token and restarts positions at zero for the next text.
// Output channel m_axis: one token per transfer; tlast flags the last token
// caused by one input transfer.
// Throughput: one input byte per cycle while s_axis_tready is high. A byte
// gives zero, one or two tokens; the output side drains one token per cycle
// while m_axis_tready is high, so a byte that both ends a word or number and
// forms a token of its own queues two tokens. Tokens are registered into a
// four-entry output queue at the input transfer that ends them;
// s_axis_tready is high while at least two entries are free, so a stalled
// receiver backs up into the input once more than two tokens are queued.
// Held tokens stay stable. Reset (rst, synchronous) empties the queue and
// returns the scanner to idle at position zero.
`timescale 1ns / 1ps

module keyword_token_lexer_unit #(
  parameter int POSITION_BITS = 16,
  parameter int KEYWORD_CHARS = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [kwtl_pkg::TDATA_BITS-1:0] m_axis_tdata,
  // [3:0] token_type, [19:4] token_start, [35:20] token_length,
  // [43:36] token_char, [47:44] zero
  output logic        m_axis_tlast    // last
);

  localparam int QDEPTH = 4;

  kwtl_pkg::scan_out_t scan_res;
  kwtl_pkg::token_t    queue [QDEPTH];
  logic [1:0]          head, tail;
  logic [2:0]          count;
  logic                accept, pop;
  kwtl_pkg::token_t    head_tok;

  assign s_axis_tready = count <= 3'd2;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = count != 3'd0;
  assign pop           = m_axis_tvalid && m_axis_tready;

  kwtl_scan #(
    .POSITION_BITS(POSITION_BITS),
    .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .ch          (s_axis_tdata),
    .end_of_text (s_axis_tlast),
    .result      (scan_res)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      if (scan_res.count != 2'd0) begin
        queue[tail] <= scan_res.tok0;
      end
      if (scan_res.count == 2'd2) begin
        queue[tail + 2'd1] <= scan_res.tok1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (accept) begin
        tail <= tail + scan_res.count;
      end
      if (pop) begin
        head <= head + 2'd1;
      end
      count <= count + (accept ? {1'b0, scan_res.count} : 3'd0) - {2'b0, pop};
    end
  end

  assign head_tok     = queue[head];
  assign m_axis_tdata = {4'b0, head_tok.code, head_tok.length, head_tok.start, head_tok.kind};
  assign m_axis_tlast = head_tok.last;

endmodule

FILE: rtl/core/kwtl_scan.sv
// Scanner state and per-byte token decisions of the keyword token lexer.
`timescale 1ns / 1ps

module kwtl_scan #(
  parameter int POSITION_BITS = 16,
  parameter int KEYWORD_CHARS = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          ch,
  input  logic                end_of_text,
  output kwtl_pkg::scan_out_t result
);

  localparam int PREFIX_BITS = 8 * KEYWORD_CHARS;

  kwtl_pkg::scan_mode_t     mode, mode_next;
  logic [POSITION_BITS-1:0] position, position_next;
  logic [POSITION_BITS-1:0] start_position, start_position_next;
  logic [POSITION_BITS-1:0] run_length, run_length_next;
  logic [PREFIX_BITS-1:0]   prefix_chars, prefix_chars_next;

  logic                 is_alpha, is_digit, is_space, is_under;
  logic                 has_pend, new_valid;
  kwtl_pkg::tok_type_t  ident_kind, single_kind;
  kwtl_pkg::token_t     pend_tok, new_tok, end_tok;

  function automatic logic [15:0] sat16(input logic [POSITION_BITS-1:0] v);
    logic [31:0] ext;
    ext = 32'(v);
    return (|ext[31:16]) ? 16'hFFFF : ext[15:0];
  endfunction

  function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
    return (&v) ? v : v + POSITION_BITS'(1);
  endfunction

  assign is_alpha = (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
  assign is_digit = ch >= 8'h30 && ch <= 8'h39;
  assign is_space = ch == kwtl_pkg::CH_SPACE || (ch >= 8'd9 && ch <= 8'd13);
  assign is_under = ch == kwtl_pkg::CH_UNDERSCORE;

  always_comb begin
    ident_kind = kwtl_pkg::TT_IDENT;
    if (run_length == POSITION_BITS'(4) && prefix_chars[31:0] == kwtl_pkg::KW_FUNC) begin
      ident_kind = kwtl_pkg::TT_FUNC;
    end else if (run_length == POSITION_BITS'(6) &&
                 prefix_chars[47:0] == kwtl_pkg::KW_RETURN) begin
      ident_kind = kwtl_pkg::TT_RETURN;
    end else if (run_length == POSITION_BITS'(2) &&
                 prefix_chars[15:0] == kwtl_pkg::KW_IF) begin
      ident_kind = kwtl_pkg::TT_IF;
    end else if (run_length == POSITION_BITS'(4) &&
                 prefix_chars[31:0] == kwtl_pkg::KW_ELSE) begin
      ident_kind = kwtl_pkg::TT_ELSE;
    end else if (run_length == POSITION_BITS'(5) &&
                 prefix_chars[39:0] == kwtl_pkg::KW_PRINT) begin
      ident_kind = kwtl_pkg::TT_PRINT;
    end
  end

  always_comb begin
    case (ch)
      kwtl_pkg::CH_LBRACE:  single_kind = kwtl_pkg::TT_LBRACE;
      kwtl_pkg::CH_RBRACE:  single_kind = kwtl_pkg::TT_RBRACE;
      kwtl_pkg::CH_LPAREN:  single_kind = kwtl_pkg::TT_LPAREN;
      kwtl_pkg::CH_RPAREN:  single_kind = kwtl_pkg::TT_RPAREN;
      kwtl_pkg::CH_ASSIGN:  single_kind = kwtl_pkg::TT_ASSIGN;
      kwtl_pkg::CH_PLUS:    single_kind = kwtl_pkg::TT_PLUS;
      kwtl_pkg::CH_GREATER: single_kind = kwtl_pkg::TT_GREATER;
      default:              single_kind = kwtl_pkg::TT_UNKNOWN;
    endcase
  end

  always_comb begin
    has_pend  = mode != kwtl_pkg::MODE_IDLE;
    new_valid = !(is_space || is_alpha || is_digit);

    pend_tok.kind   = (mode == kwtl_pkg::MODE_IDENT) ? ident_kind : kwtl_pkg::TT_NUMBER;
    pend_tok.start  = sat16(start_position);
    pend_tok.length = sat16(run_length);
    pend_tok.code   = 8'd0;
    pend_tok.last   = end_of_text ? 1'b0 : !new_valid;

    new_tok.kind    = single_kind;
    new_tok.start   = sat16(position);
    new_tok.length  = 16'd1;
    new_tok.code    = ch;
    new_tok.last    = 1'b1;

    end_tok.kind    = kwtl_pkg::TT_END;
    end_tok.start   = sat16(position);
    end_tok.length  = 16'd0;
    end_tok.code    = 8'd0;
    end_tok.last    = 1'b1;
  end

  always_comb begin
    mode_next           = mode;
    position_next       = position;
    start_position_next = start_position;
    run_length_next     = run_length;
    prefix_chars_next   = prefix_chars;
    result              = '0;

    if (end_of_text) begin
      if (has_pend) begin
        result.tok0  = pend_tok;
        result.tok1  = end_tok;
        result.count = 2'd2;
      end else begin
        result.tok0  = end_tok;
        result.count = 2'd1;
      end
      mode_next           = kwtl_pkg::MODE_IDLE;
      position_next       = '0;
      start_position_next = '0;
      run_length_next     = '0;
      prefix_chars_next   = '0;
    end else if ((mode == kwtl_pkg::MODE_IDENT && (is_alpha || is_digit || is_under)) ||
                 (mode == kwtl_pkg::MODE_NUMBER && is_digit)) begin
      for (int i = 0; i < KEYWORD_CHARS; i++) begin
        if (run_length == POSITION_BITS'(i)) begin
          prefix_chars_next[8*i +: 8] = ch;
        end
      end
      run_length_next = sat_inc(run_length);
      position_next   = sat_inc(position);
    end else begin
      if (has_pend) begin
        result.tok0  = pend_tok;
        result.tok1  = new_tok;
        result.count = new_valid ? 2'd2 : 2'd1;
      end else begin
        result.tok0  = new_tok;
        result.count = {1'b0, new_valid};
      end
      mode_next         = kwtl_pkg::MODE_IDLE;
      run_length_next   = '0;
      prefix_chars_next = '0;
      position_next     = sat_inc(position);
      if (is_alpha || is_digit) begin
        mode_next           = is_alpha ? kwtl_pkg::MODE_IDENT : kwtl_pkg::MODE_NUMBER;
        start_position_next = position;
        run_length_next     = POSITION_BITS'(1);
        prefix_chars_next   = PREFIX_BITS'(ch);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= kwtl_pkg::MODE_IDLE;
      position       <= '0;
      start_position <= '0;
      run_length     <= '0;
      prefix_chars   <= '0;
    end else if (accept) begin
      mode           <= mode_next;
      position       <= position_next;
      start_position <= start_position_next;
      run_length     <= run_length_next;
      prefix_chars   <= prefix_chars_next;
    end
  end

endmodule

FILE: rtl/core/kwtl_checker.sv
// Port-level assertions for the keyword token lexer and their bind.
`timescale 1ns / 1ps
`include "keyword_token_lexer_unit_assert.svh"

module kwtl_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic        stalled;
  logic [48:0] out_word;
  logic [3:0]  tok_kind;
  logic [15:0] tok_len;
  logic [7:0]  tok_char;

  assign stalled  = m_axis_tvalid && !m_axis_tready;
  assign out_word = {m_axis_tlast, m_axis_tdata};
  assign tok_kind = m_axis_tdata[3:0];
  assign tok_len  = m_axis_tdata[35:20];
  assign tok_char = m_axis_tdata[43:36];

  property p_hold;
    stalled |=> m_axis_tvalid && $stable(out_word);
  endproperty

  property p_end_tok;
    m_axis_tvalid && tok_kind == kwtl_pkg::TT_END |->
      m_axis_tlast && tok_len == 16'd0 && tok_char == 8'd0;
  endproperty

  property p_single;
    m_axis_tvalid && tok_kind >= kwtl_pkg::TT_LBRACE && tok_kind <= kwtl_pkg::TT_UNKNOWN |->
      tok_len == 16'd1 && m_axis_tlast;
  endproperty

  property p_reset;
    rst |=> !m_axis_tvalid && s_axis_tready;
  endproperty

  `KWTL_ASSERT_RUN(a_hold_on_stall, p_hold, "token changed while stalled")
  `KWTL_ASSERT_RUN(a_end_is_last, p_end_tok, "malformed end token")
  `KWTL_ASSERT_RUN(a_single_len, p_single, "single-character token malformed")
  `KWTL_ASSERT_ALWAYS(a_reset_empty, p_reset, "queue not empty after reset")

endmodule

bind keyword_token_lexer_unit kwtl_checker u_checker (.*);
